>>> hw/rtl/mlsm_pkg.sv
// shared types and constants of the matrix line sum max block
// depends on nothing; imported by every module of the block
`default_nettype none

package mlsm_pkg;

    localparam int ELEM_W       = 16;
    localparam int SIDE_CFG_W   = 8;
    localparam int OUT_W        = 22;
    localparam int MAX_SIDE_DEF = 128;
    localparam int SUM_W_DEF    = ELEM_W + $clog2(MAX_SIDE_DEF) + 1;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 8'd100;
    localparam logic [OUT_W-1:0]      OUT_MAX    = 22'h3FFFFF;

    // control that travels with one request down the max pipeline
    typedef struct packed {
        logic valid;
        logic last;   // last element of a matrix
    } t_stage_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/mlsm_cell.sv
// one cell of the column sum line: holds one column sum
// depends on mlsm_pkg
`default_nettype none

module mlsm_cell
    import mlsm_pkg::*;
#(
    parameter int SUM_W = SUM_W_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire                    i_tail,
    input  wire signed [SUM_W-1:0] i_wr,
    input  wire signed [SUM_W-1:0] i_next,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [SUM_W-1:0] r_sum;

    // the tail cell takes the fresh sum, the others take their neighbor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= i_tail ? i_wr : i_next;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

>>> hw/rtl/mlsm_col_chain.sv
// line of column sum cells; a sum written at the tail is at cell 0 when its
// column comes up in the next row. depends on mlsm_pkg, mlsm_cell
`default_nettype none

module mlsm_col_chain
    import mlsm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF,
    parameter int SUM_W    = SUM_W_DEF,
    parameter int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire        [IDX_W-1:0] i_last_idx,
    input  wire signed [SUM_W-1:0] i_wr,
    output logic signed [SUM_W-1:0] o_head
);

    logic signed [SUM_W-1:0] w_sum [MAX_SIDE];

    for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
        logic signed [SUM_W-1:0] w_next;
        logic                    w_tail;

        if (k == MAX_SIDE - 1) begin : g_end
            assign w_next = i_wr;
        end else begin : g_mid
            assign w_next = w_sum[k+1];
        end

        assign w_tail = (IDX_W'(k) == i_last_idx);

        mlsm_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_tail (w_tail),
            .i_wr   (i_wr),
            .i_next (w_next),
            .o_sum  (w_sum[k])
        );
    end

    assign o_head = w_sum[0];

endmodule

`default_nettype wire

>>> hw/rtl/mlsm_max_pipe.sv
// max tree over line sum candidates, running best and result register
// depends on mlsm_pkg
`default_nettype none

module mlsm_max_pipe
    import mlsm_pkg::*;
#(
    parameter int SUM_W = SUM_W_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire                    i_clear,
    input  t_stage_ctl             i_ctl,
    input  wire signed [SUM_W-1:0] i_col,
    input  wire signed [SUM_W-1:0] i_row,
    input  wire signed [SUM_W-1:0] i_main,
    input  wire signed [SUM_W-1:0] i_anti,
    output logic                   o_res_valid,
    output logic       [OUT_W-1:0] o_best,
    output logic                   o_busy
);

    t_stage_ctl              r_s2_ctl;
    t_stage_ctl              r_s3_ctl;
    logic signed [SUM_W-1:0] r_s2_a;
    logic signed [SUM_W-1:0] r_s2_b;
    logic signed [SUM_W-1:0] r_s3_m;
    logic signed [SUM_W-1:0] r_best;
    logic                    r_out_valid;
    logic        [OUT_W-1:0] r_out;

    logic signed [SUM_W-1:0] n_best;
    logic signed [31:0]      w_best_ext;
    logic        [OUT_W-1:0] w_sat;

    always_comb begin
        n_best     = (r_s3_m > r_best) ? r_s3_m : r_best;
        w_best_ext = 32'(n_best);
        if (w_best_ext > $signed({10'd0, OUT_MAX})) begin
            w_sat = OUT_MAX;
        end else begin
            w_sat = w_best_ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl    <= '0;
            r_s3_ctl    <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_clear) begin
            r_best <= '0;
        end else if (i_adv) begin
            r_s2_ctl <= i_ctl;
            r_s3_ctl <= r_s2_ctl;
            if (r_s3_ctl.valid && r_s3_ctl.last) begin
                r_out_valid <= 1'b1;
                r_best      <= '0;
            end else begin
                r_out_valid <= 1'b0;
                if (r_s3_ctl.valid) begin
                    r_best <= n_best;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_a <= (i_col > i_row) ? i_col : i_row;
            r_s2_b <= (i_main > i_anti) ? i_main : i_anti;
            r_s3_m <= (r_s2_a > r_s2_b) ? r_s2_a : r_s2_b;
            if (r_s3_ctl.valid && r_s3_ctl.last) begin
                r_out <= w_sat;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_best      = r_out;
    // something still in the max stages or a result waiting
    assign o_busy      = r_s2_ctl.valid || r_s3_ctl.valid || r_out_valid;

endmodule

`default_nettype wire

>>> hw/rtl/matrix_line_sum_max.sv
// top level of the matrix line sum max block: position counters, row and
// diagonal sums, column sum cell line and max pipeline
// depends on mlsm_pkg, mlsm_col_chain, mlsm_max_pipe
//
// channel   dir  handshake                       payload
// element   in   i_elem_valid / o_elem_ready     i_element (16b signed)
// result    out  o_res_valid  / i_res_ready      o_best_line_sum (22b)
// config    in   i_cfg_valid  / o_cfg_ready      i_matrix_side (8b)
//
// one element request is taken every clock cycle unless a waiting result or a
// pending side write holds it off; the column sums move one cell along the line
// per element, so no cycle is spent on a column lookup. a result passes through
// the candidate stage, two max stages and the result register after the edge
// that takes the last element of its matrix. a waiting result stalls the whole
// pipeline, so o_elem_ready follows i_res_ready while a result is held and no side
// write is pending; a pending side write holds off elements and is taken once the
// pipeline is empty and no result is held; reset gives side 100, clears positions and
// sums; column cells need none because row 0 writes each column before it is read
`default_nettype none

module matrix_line_sum_max
    import mlsm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_elem_valid,
    output logic                    o_elem_ready,
    input  wire signed [ELEM_W-1:0] i_element,
    output logic                    o_res_valid,
    input  wire                     i_res_ready,
    output logic        [OUT_W-1:0] o_best_line_sum,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire    [SIDE_CFG_W-1:0] i_matrix_side
);

    localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SUM_W = ELEM_W + $clog2(MAX_SIDE) + 1;

    // side clamped to 1..MAX_SIDE, kept as its last index
    function automatic logic [IDX_W-1:0] last_index(input logic [SIDE_CFG_W-1:0] v);
        int s;
        s = int'(v);
        if (s == 0) s = 1;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return IDX_W'(s - 1);
    endfunction

    // position and running sums
    logic        [IDX_W-1:0] r_last_idx;
    logic        [IDX_W-1:0] r_row;
    logic        [IDX_W-1:0] r_col;
    logic signed [SUM_W-1:0] r_row_total;
    logic signed [SUM_W-1:0] r_main;
    logic signed [SUM_W-1:0] r_anti;

    // first pipeline stage: candidates, zero where not due (best floors at 0)
    t_stage_ctl              r_s1_ctl;
    logic signed [SUM_W-1:0] r_s1_col;
    logic signed [SUM_W-1:0] r_s1_row;
    logic signed [SUM_W-1:0] r_s1_main;
    logic signed [SUM_W-1:0] r_s1_anti;

    logic                    w_adv;
    logic                    w_accept;
    logic                    w_cfg_wr;
    logic                    w_pipe_busy;
    logic                    w_last_row;
    logic                    w_last_col;
    logic                    w_on_main;
    logic                    w_on_anti;
    logic signed [SUM_W-1:0] w_x;
    logic signed [SUM_W-1:0] w_head;
    logic signed [SUM_W-1:0] w_col_new;
    logic signed [SUM_W-1:0] w_row_new;
    logic signed [SUM_W-1:0] w_main_new;
    logic signed [SUM_W-1:0] w_anti_new;

    // pipeline moves whenever the result register is free or being taken
    assign w_adv        = !o_res_valid || i_res_ready;
    // a pending side write blocks elements so the pipeline can drain
    assign o_elem_ready = w_adv && !i_cfg_valid;
    // side write only with nothing in flight in the pipeline and no result held
    assign o_cfg_ready  = !r_s1_ctl.valid && !w_pipe_busy;
    assign w_accept     = i_elem_valid && o_elem_ready;
    assign w_cfg_wr     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        w_x        = SUM_W'(i_element);
        w_last_row = (r_row == r_last_idx);
        w_last_col = (r_col == r_last_idx);
        w_on_main  = (r_row == r_col);
        w_on_anti  = (({1'b0, r_row} + {1'b0, r_col}) == {1'b0, r_last_idx});
        // row 0 starts each column fresh
        w_col_new  = (r_row == '0) ? w_x : w_head + w_x;
        w_row_new  = r_row_total + w_x;
        w_main_new = w_on_main ? r_main + w_x : r_main;
        w_anti_new = w_on_anti ? r_anti + w_x : r_anti;
    end

    mlsm_col_chain #(
        .MAX_SIDE (MAX_SIDE),
        .SUM_W    (SUM_W),
        .IDX_W    (IDX_W)
    ) u_col_chain (
        .i_clk      (i_clk),
        .i_en       (w_accept),
        .i_last_idx (r_last_idx),
        .i_wr       (w_col_new),
        .o_head     (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx  <= last_index(SIDE_RESET);
            r_row       <= '0;
            r_col       <= '0;
            r_row_total <= '0;
            r_main      <= '0;
            r_anti      <= '0;
        end else if (w_cfg_wr) begin
            // a side change starts a new matrix
            r_last_idx  <= last_index(i_matrix_side);
            r_row       <= '0;
            r_col       <= '0;
            r_row_total <= '0;
            r_main      <= '0;
            r_anti      <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col       <= '0;
                r_row       <= w_last_row ? '0 : r_row + 1'b1;
                r_row_total <= '0;
            end else begin
                r_col       <= r_col + 1'b1;
                r_row_total <= w_row_new;
            end
            if (w_last_row && w_last_col) begin
                r_main <= '0;
                r_anti <= '0;
            end else begin
                r_main <= w_main_new;
                r_anti <= w_anti_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_adv) begin
            r_s1_ctl.valid <= w_accept;
            r_s1_ctl.last  <= w_last_row && w_last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_col  <= w_last_row ? w_col_new : '0;
            r_s1_row  <= w_last_col ? w_row_new : '0;
            r_s1_main <= (w_last_row && w_last_col) ? w_main_new : '0;
            r_s1_anti <= (w_last_row && w_last_col) ? w_anti_new : '0;
        end
    end

    mlsm_max_pipe #(
        .SUM_W (SUM_W)
    ) u_max_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_clear     (w_cfg_wr),
        .i_ctl       (r_s1_ctl),
        .i_col       (r_s1_col),
        .i_row       (r_s1_row),
        .i_main      (r_s1_main),
        .i_anti      (r_s1_anti),
        .o_res_valid (o_res_valid),
        .o_best      (o_best_line_sum),
        .o_busy      (w_pipe_busy)
    );

`ifndef ASSERT_OFF
    // position never runs past the side in use
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= r_last_idx) && (r_col <= r_last_idx))
        else $error("matrix position beyond side");

    // a side write restarts the matrix at its first element
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_row == '0) && (r_col == '0))
        else $error("position not cleared by side write");

    // the last element wraps the position back to the start and clears the diagonal sums
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_cfg_wr && w_last_row && w_last_col)
        |=> (r_row == '0) && (r_col == '0) && (r_main == '0) && (r_anti == '0))
        else $error("matrix state not cleared after last element");
`endif

endmodule

`default_nettype wire
